FILE: rtl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and codes of the sequence reorder buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_DELIVERED = 2'd0;
  localparam status_t ST_DUPLICATE = 2'd1;
  localparam status_t ST_BEYOND    = 2'd2;

  typedef struct packed {
    logic    in_window;
    status_t drop_status;
  } cls_t;

endpackage

FILE: rtl/srb_classify.sv
// ----------------------------------------------------------------------------
// srb_classify
// Sorts an incoming sequence number against the expected one (modulo 2^32)
// and works out its ring slot.
// ----------------------------------------------------------------------------
module srb_classify #(
  parameter int WINDOW = 16
) (
  input  logic [31:0]                                  seq,
  input  logic [31:0]                                  expected,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] head,
  output srb_pkg::cls_t                                cls,
  output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] slot
);

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [31:0] seq_gap;
  logic        behind;
  logic        beyond;
  logic [SW:0] sum;

  assign seq_gap = seq - expected;
  assign behind  = seq_gap[31];
  assign beyond  = !behind && (seq_gap >= 32'(WINDOW));

  assign cls.in_window   = !behind && !beyond;
  assign cls.drop_status = behind ? srb_pkg::ST_DUPLICATE : srb_pkg::ST_BEYOND;

  // gap < WINDOW when in window, so the sum stays below twice the ring size
  assign sum  = {1'b0, head} + {1'b0, seq_gap[SW-1:0]};
  assign slot = (sum >= (SW+1)'(WINDOW)) ? SW'(sum - (SW+1)'(WINDOW)) : sum[SW-1:0];

endmodule

FILE: rtl/sequence_reorder_buffer.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Receive-side reorder buffer: stores out-of-order words in a ring memory,
// drops duplicates and out-of-window words, releases in-order runs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall  | in_sequence_req, in_payload_handle
//  out     | out       | out_valid/out_stall| out_status, out_sequence,
//          |           |                    | out_payload, out_last
//
//  A dropped word gives one result in the cycle after acceptance.
//  A stored word is written first, then each released word takes a memory
//  read (S_RD) and an output load (S_OUT), which waits while out is stalled;
//  when the word is stored and nothing is released, S_RD returns to idle.
//  The payload memory's single read port sets the release pace.
//  Reset (rst_n low, synchronous) clears all held flags at once; no sweep.
//  Input stalls while a run drains or the output register cannot be loaded.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer #(
  parameter int WINDOW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_sequence_req,
  input  logic [31:0]           in_payload_handle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output srb_pkg::status_t      out_status,
  output logic [31:0]           out_sequence,
  output logic [31:0]           out_payload,
  output logic                  out_last
);

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [31:0]       expected_r, expected_nxt;
  logic [SW-1:0]     head_r, head_nxt;
  logic [WINDOW-1:0] valid_r, valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  srb_pkg::status_t  out_status_r, out_status_nxt;
  logic [31:0]       out_seq_r, out_seq_nxt;
  logic [31:0]       out_pay_r, out_pay_nxt;
  logic              out_last_r, out_last_nxt;
  logic [31:0]       rel_seq_r, rel_seq_nxt;
  logic              rel_last_r, rel_last_nxt;
  logic [31:0]       rd_data_r;

  logic [31:0]       mem [WINDOW];

  srb_pkg::cls_t     cls;
  logic [SW-1:0]     slot;
  logic [SW-1:0]     head_inc;
  logic              in_acc;
  logic              out_free;
  logic              mem_we;
  logic              mem_re;

  srb_classify #(
    .WINDOW(WINDOW)
  ) u_classify (
    .seq      (in_sequence_req),
    .expected (expected_r),
    .head     (head_r),
    .cls      (cls),
    .slot     (slot)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    expected_nxt   = expected_r;
    head_nxt       = head_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_seq_nxt    = out_seq_r;
    out_pay_nxt    = out_pay_r;
    out_last_nxt   = out_last_r;
    rel_seq_nxt    = rel_seq_r;
    rel_last_nxt   = rel_last_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!cls.in_window || valid_r[slot]) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = cls.in_window ? srb_pkg::ST_DUPLICATE : cls.drop_status;
            out_seq_nxt    = in_sequence_req;
            out_pay_nxt    = '0;
            out_last_nxt   = 1'b1;
          end else begin
            mem_we          = 1'b1;
            valid_nxt[slot] = 1'b1;
            state_nxt       = S_RD;
          end
        end
      end
      S_RD: begin
        if (valid_r[head_r]) begin
          mem_re            = 1'b1;
          valid_nxt[head_r] = 1'b0;
          rel_seq_nxt       = expected_r;
          rel_last_nxt      = !valid_r[head_inc];
          expected_nxt      = expected_r + 32'd1;
          head_nxt          = head_inc;
          state_nxt         = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = srb_pkg::ST_DELIVERED;
          out_seq_nxt    = rel_seq_r;
          out_pay_nxt    = rd_data_r;
          out_last_nxt   = rel_last_r;
          state_nxt      = rel_last_r ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      expected_r  <= '0;
      head_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      expected_r  <= expected_nxt;
      head_r      <= head_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_seq_r    <= out_seq_nxt;
    out_pay_r    <= out_pay_nxt;
    out_last_r   <= out_last_nxt;
    rel_seq_r    <= rel_seq_nxt;
    rel_last_r   <= rel_last_nxt;
  end

  // payload ring
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot] <= in_payload_handle;
    end
    if (mem_re) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_sequence = out_seq_r;
  assign out_payload  = out_pay_r;
  assign out_last     = out_last_r;

  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (state_r == S_IDLE))
    else $error("word accepted outside idle");

  a_drop_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cls.in_window) |=> (out_valid_r && out_last_r &&
                                    out_status_r != srb_pkg::ST_DELIVERED))
    else $error("dropped word gave no final result");

  a_release_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && valid_r[head_r]) |=>
      (expected_r == $past(expected_r) + 32'd1 && !valid_r[$past(head_r)]))
    else $error("release did not advance expected number");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=>
      (out_valid_r && out_status_r == srb_pkg::ST_DELIVERED))
    else $error("released word not loaded");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (valid_r == '0 && state_r == S_IDLE && !out_valid_r))
    else $error("reset left state behind");

endmodule

FILE: test/tb_sequence_reorder_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequence_reorder_buffer
// Self-checking bench for the sequence reorder buffer. A directed table walks
// the window edges, wrap-around distances and duplicate cases, then random
// in-order runs are sent shuffled, with resends, gaps and noise mixed in.
// Every output word is checked against the table or a behavioural ring model,
// under bursty input and a patterned output stall, including one long stall.
// ----------------------------------------------------------------------------
module tb_sequence_reorder_buffer;

  localparam int WIN          = 16;
  localparam int DIR_ROWS     = 11;
  localparam int RANDOM_WORDS = 320;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    srb_pkg::status_t st;
    logic [31:0]      seq_no;
    logic [31:0]      handle;
    logic             last_flag;
  } rx_word_t;

  typedef struct packed {
    logic [31:0] seq_no;
    logic [31:0] handle;
    logic        fixed;
    rx_word_t    want;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [31:0]      in_sequence_req;
  logic [31:0]      in_payload_handle;
  logic             out_valid;
  logic             out_stall;
  srb_pkg::status_t out_status;
  logic [31:0]      out_sequence;
  logic [31:0]      out_payload;
  logic             out_last;

  // model of the ring
  logic [31:0] next_seq;
  bit          slot_full [WIN];
  logic [31:0] slot_handle [WIN];
  int          ring_base;

  rx_word_t    fresh_words [$];
  rx_word_t    due_words [$];
  rx_word_t    head_word;
  dir_row_t    dir_rows [DIR_ROWS];

  int          mismatches  = 0;
  int          words_in    = 0;
  int          n_delivered = 0;
  int          n_dup       = 0;
  int          n_beyond    = 0;
  int          burst_left  = 0;
  bit          hold_asked  = 1'b0;
  bit          hold_done   = 1'b0;

  sequence_reorder_buffer #(
    .WINDOW(WIN)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sequence_req  (in_sequence_req),
    .in_payload_handle(in_payload_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_sequence     (out_sequence),
    .out_payload      (out_payload),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("%0t: %s: expected %h, got %h", $time, what, want, got);
  endtask

  function automatic void reorder_predict(input logic [31:0] s, input logic [31:0] h);
    logic [31:0] seq_gap;
    int          slot;
    int          n;
    rx_word_t    w;
    fresh_words.delete();
    seq_gap = s - next_seq;
    if (seq_gap[31]) begin
      w = '{srb_pkg::ST_DUPLICATE, s, 32'h0, 1'b1};
      fresh_words = {fresh_words, w};
    end else if (seq_gap >= WIN) begin
      w = '{srb_pkg::ST_BEYOND, s, 32'h0, 1'b1};
      fresh_words = {fresh_words, w};
    end else begin
      slot = (ring_base + int'(seq_gap)) % WIN;
      if (slot_full[slot]) begin
        w = '{srb_pkg::ST_DUPLICATE, s, 32'h0, 1'b1};
        fresh_words = {fresh_words, w};
      end else begin
        slot_full[slot]   = 1'b1;
        slot_handle[slot] = h;
        n = 0;
        while (n < WIN && slot_full[ring_base]) begin
          w.st        = srb_pkg::ST_DELIVERED;
          w.seq_no    = next_seq;
          w.handle    = slot_handle[ring_base];
          slot_full[ring_base] = 1'b0;
          ring_base   = (ring_base + 1) % WIN;
          next_seq    = next_seq + 32'd1;
          n++;
          w.last_flag = (n == WIN) || !slot_full[ring_base];
          fresh_words = {fresh_words, w};
        end
      end
    end
  endfunction

  task automatic drive_word(input logic [31:0] s, input logic [31:0] h,
                            input logic use_fixed, input rx_word_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_sequence_req   <= s;
    in_payload_handle <= h;
    do @(posedge clk); while (in_stall);
    reorder_predict(s, h);
    if (use_fixed) begin
      due_words = {due_words, want};
    end else begin
      due_words = {due_words, fresh_words};
    end
    words_in++;
  endtask

  task automatic drain_out();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // output checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      case (out_status)
        srb_pkg::ST_DELIVERED: n_delivered++;
        srb_pkg::ST_DUPLICATE: n_dup++;
        default:               n_beyond++;
      endcase
      if (due_words.size() == 0) begin
        report_mismatch("word with nothing expected, sequence", 32'h0, out_sequence);
      end else begin
        head_word = due_words.pop_front();
        if (out_status !== head_word.st)
          report_mismatch("status", 32'(head_word.st), 32'(out_status));
        if (out_sequence !== head_word.seq_no)
          report_mismatch("sequence", head_word.seq_no, out_sequence);
        if (out_payload !== head_word.handle)
          report_mismatch("payload", head_word.handle, out_payload);
        if (out_last !== head_word.last_flag)
          report_mismatch("last", 32'(head_word.last_flag), 32'(out_last));
      end
    end
  end

  // receiver stall pattern, with one long hold on request
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(4, 50);
      end
      mode_left--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  initial begin
    int          i;
    int          j;
    int          tmp;
    int          len;
    int          skip;
    int          pick;
    int          order [WIN];
    logic [31:0] base;
    bit          paused;

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_sequence_req   = 32'h0;
    in_payload_handle = 32'h0;
    paused            = 1'b0;
    next_seq          = 32'h0;
    ring_base         = 0;
    foreach (slot_full[i]) slot_full[i] = 1'b0;

    dir_rows[0]  = '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                     '{srb_pkg::ST_DELIVERED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1}};
    dir_rows[1]  = '{32'h0000_0000, 32'h0000_1234, 1'b1,
                     '{srb_pkg::ST_DUPLICATE, 32'h0000_0000, 32'h0, 1'b1}};
    dir_rows[2]  = '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                     '{srb_pkg::ST_DUPLICATE, 32'hFFFF_FFFF, 32'h0, 1'b1}};
    dir_rows[3]  = '{32'h8000_0001, 32'h5555_5555, 1'b1,
                     '{srb_pkg::ST_DUPLICATE, 32'h8000_0001, 32'h0, 1'b1}};
    dir_rows[4]  = '{32'h8000_0000, 32'hAAAA_AAAA, 1'b1,
                     '{srb_pkg::ST_BEYOND, 32'h8000_0000, 32'h0, 1'b1}};
    dir_rows[5]  = '{32'h0000_0011, 32'h0000_0001, 1'b1,
                     '{srb_pkg::ST_BEYOND, 32'h0000_0011, 32'h0, 1'b1}};
    dir_rows[6]  = '{32'h0000_0010, 32'h8000_0000, 1'b0, '0};
    dir_rows[7]  = '{32'h0000_0010, 32'h0000_0000, 1'b1,
                     '{srb_pkg::ST_DUPLICATE, 32'h0000_0010, 32'h0, 1'b1}};
    dir_rows[8]  = '{32'h0000_0003, 32'h0000_0003, 1'b0, '0};
    dir_rows[9]  = '{32'h0000_0001, 32'h7FFF_FFFF, 1'b0, '0};
    dir_rows[10] = '{32'h0000_0002, 32'h0000_0000, 1'b0, '0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      drive_word(dir_rows[i].seq_no, dir_rows[i].handle, dir_rows[i].fixed,
                 dir_rows[i].want);
    end

    while (words_in < DIR_ROWS + RANDOM_WORDS) begin
      if (!hold_asked && words_in >= DIR_ROWS + 150) hold_asked = 1'b1;
      if (!paused && words_in >= DIR_ROWS + 250) begin
        paused = 1'b1;
        drain_out();
      end
      pick = $urandom_range(0, 99);
      if (pick < 87) begin
        // shuffled in-order run; a broken one leaves a hole behind
        base = next_seq;
        len  = ($urandom_range(0, 6) == 0) ? WIN : $urandom_range(1, 6);
        for (i = 0; i < len; i++) order[i] = i;
        for (i = len - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        skip = (pick >= 75) ? $urandom_range(0, len - 1) : -1;
        for (i = 0; i < len; i++) begin
          if (order[i] != skip) drive_word(base + order[i], $urandom, 1'b0, '0);
          if ($urandom_range(0, 9) == 0) begin
            drive_word(base + order[$urandom_range(0, i)], $urandom, 1'b0, '0);
          end
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       drive_word($urandom, $urandom, 1'b0, '0);
          1:       drive_word(next_seq + $urandom_range(0, 40), $urandom, 1'b0, '0);
          default: drive_word(next_seq - $urandom_range(1, 40), $urandom, 1'b0, '0);
        endcase
      end
    end

    drain_out();
    $display("Run covered %0d input words, %0d from the directed table.",
             words_in, DIR_ROWS);
    $display("Checked %0d delivered, %0d duplicate and %0d out-of-window words.",
             n_delivered, n_dup, n_beyond);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sequence_reorder_buffer.f
rtl/srb_pkg.sv
rtl/srb_classify.sv
rtl/sequence_reorder_buffer.sv
test/tb_sequence_reorder_buffer.sv
